### hw/rtl/lcs_pkg.sv
// Shared types, sizes and codes for the longest common substring block.
// Used by every file under hw/rtl; depends on nothing.
package lcs_pkg;

  // Reference store depth and streamed index width
  localparam int MAX_REF_LEN       = 256;
  localparam int STREAM_INDEX_BITS = 16;

  // Derived sizes
  localparam int IDX_W = $clog2(MAX_REF_LEN);
  localparam int CNT_W = $clog2(MAX_REF_LEN + 1);
  localparam int RUN_W = $clog2(MAX_REF_LEN + 1);

  // Fixed field widths of the stream channels
  localparam int SYM_W      = 8;
  localparam int OP_W       = 2;
  localparam int LEN_W      = 9;
  localparam int END_S_W    = 16;
  localparam int END_R_W    = 8;
  localparam int FIELDS_W   = LEN_W + END_S_W + END_R_W;
  localparam int M_TDATA_W  = ((FIELDS_W + 7) / 8) * 8;
  localparam int S_TDATA_W  = SYM_W;

  // Request opcodes
  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_STREAM = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DELIVER
  } state_t;

  // Row token that walks down the cell chain
  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic [RUN_W-1:0] diag;
    logic [RUN_W-1:0] best_len;
    logic [IDX_W-1:0] best_col;
    logic             hit;
  } token_t;

  // Broadcast control from the controller to every cell
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [SYM_W-1:0] wr_sym;
    logic             clear_all;
    logic             clear_runs;
  } cell_ctl_t;

endpackage

### hw/rtl/lcs_cell.sv
// One column of the match table: a reference symbol, its run length and
// the token stage toward the next column. Depends on lcs_pkg.
module lcs_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic [lcs_pkg::IDX_W-1:0] idx,
  input  lcs_pkg::cell_ctl_t ctl,
  input  logic               in_valid,
  input  lcs_pkg::token_t    in_tok,
  output logic               out_valid,
  output lcs_pkg::token_t    out_tok
);

  logic                       active;
  logic [lcs_pkg::SYM_W-1:0]  ref_sym;
  logic [lcs_pkg::RUN_W-1:0]  run;
  logic [lcs_pkg::RUN_W-1:0]  v;
  logic                       wr_hit;
  lcs_pkg::token_t            tok_next;

  // Extend the diagonal run on a match, else restart at zero; hand the old
  // run on as the next diagonal and keep the strictly longer run
  always_comb begin
    wr_hit   = ctl.wr_en && (ctl.wr_idx == idx);
    v        = (in_tok.sym == ref_sym) ? in_tok.diag + lcs_pkg::RUN_W'(1) : '0;
    tok_next = in_tok;
    if (active) begin
      tok_next.diag = run;
      if (v > in_tok.best_len) begin
        tok_next.best_len = v;
        tok_next.best_col = idx;
        tok_next.hit      = 1'b1;
      end
    end
  end

  // Column state: load on append, clear on request, update on a token
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      run    <= '0;
    end else if (ctl.clear_all) begin
      active <= 1'b0;
      run    <= '0;
    end else if (ctl.clear_runs) begin
      run <= '0;
    end else if (wr_hit) begin
      active <= 1'b1;
      run    <= '0;
    end else if (in_valid && active) begin
      run <= v;
    end
  end

  // Reference symbol holds no reset value
  always_ff @(posedge clk) begin
    if (wr_hit) begin
      ref_sym <= ctl.wr_sym;
    end
  end

  // Token valid advances one column per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  // Advance the token to the next column
  always_ff @(posedge clk) begin
    out_tok <= tok_next;
  end

endmodule

### hw/rtl/lcs_ctrl.sv
// Request decoder, row sequencer and result register for the block.
// Depends on lcs_pkg; drives the broadcast control of the cell chain.
module lcs_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [lcs_pkg::S_TDATA_W-1:0]   s_tdata,
  input  logic [lcs_pkg::OP_W-1:0]        s_tuser,
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [lcs_pkg::M_TDATA_W-1:0]   m_tdata,
  output logic [0:0]                      m_tuser,
  output lcs_pkg::cell_ctl_t              cell_ctl,
  output logic                            inj_valid,
  output lcs_pkg::token_t                 inj_tok,
  input  logic                            done_valid,
  input  lcs_pkg::token_t                 done_tok
);

  localparam logic [lcs_pkg::STREAM_INDEX_BITS-1:0] ROW_MAX = '1;

  lcs_pkg::state_t                         state;
  lcs_pkg::state_t                         state_next;
  logic [lcs_pkg::CNT_W-1:0]               ref_count;
  logic [lcs_pkg::STREAM_INDEX_BITS-1:0]   row_index;
  logic [lcs_pkg::RUN_W-1:0]               best_len;
  logic [lcs_pkg::STREAM_INDEX_BITS-1:0]   best_row;
  logic [lcs_pkg::IDX_W-1:0]               best_col;
  logic                                    last_q;
  logic                                    accept;
  logic                                    deliver_fire;
  lcs_pkg::op_t                            op;

  // Decode the request
  always_comb begin
    op           = lcs_pkg::op_t'(s_tuser);
    accept       = s_tvalid && s_tready;
    deliver_fire = (state == lcs_pkg::ST_DELIVER) && (!m_tvalid || m_tready);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      lcs_pkg::ST_IDLE: begin
        if (accept && op == lcs_pkg::OP_STREAM) begin
          state_next = lcs_pkg::ST_SWEEP;
        end
      end
      lcs_pkg::ST_SWEEP: begin
        if (done_valid) begin
          state_next = last_q ? lcs_pkg::ST_DELIVER : lcs_pkg::ST_IDLE;
        end
      end
      lcs_pkg::ST_DELIVER: begin
        if (deliver_fire) begin
          state_next = lcs_pkg::ST_IDLE;
        end
      end
      default: state_next = lcs_pkg::ST_IDLE;
    endcase
  end

  // Outputs toward the input channel and the cells
  always_comb begin
    s_tready            = (state == lcs_pkg::ST_IDLE);
    cell_ctl.wr_en      = accept && (op == lcs_pkg::OP_APPEND) &&
                          (ref_count < lcs_pkg::CNT_W'(lcs_pkg::MAX_REF_LEN));
    cell_ctl.wr_idx     = ref_count[lcs_pkg::IDX_W-1:0];
    cell_ctl.wr_sym     = s_tdata[lcs_pkg::SYM_W-1:0];
    cell_ctl.clear_all  = accept && (op == lcs_pkg::OP_CLEAR);
    cell_ctl.clear_runs = deliver_fire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lcs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Reference length, row index and best run
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_count <= '0;
      row_index <= '0;
      best_len  <= '0;
      best_row  <= '0;
      best_col  <= '0;
      last_q    <= 1'b0;
    end else if (cell_ctl.clear_all) begin
      ref_count <= '0;
      row_index <= '0;
      best_len  <= '0;
      best_row  <= '0;
      best_col  <= '0;
    end else if (deliver_fire) begin
      row_index <= '0;
      best_len  <= '0;
      best_row  <= '0;
      best_col  <= '0;
    end else begin
      if (cell_ctl.wr_en) begin
        ref_count <= ref_count + lcs_pkg::CNT_W'(1);
      end
      if (accept && op == lcs_pkg::OP_STREAM) begin
        last_q <= s_tlast;
      end
      if (state == lcs_pkg::ST_SWEEP && done_valid) begin
        if (done_tok.hit) begin
          best_len <= done_tok.best_len;
          best_col <= done_tok.best_col;
          best_row <= row_index;
        end
        if (row_index != ROW_MAX) begin
          row_index <= row_index + lcs_pkg::STREAM_INDEX_BITS'(1);
        end
      end
    end
  end

  // Launch a row token into the first cell
  always_ff @(posedge clk) begin
    if (rst) begin
      inj_valid <= 1'b0;
    end else begin
      inj_valid <= accept && (op == lcs_pkg::OP_STREAM);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      inj_tok <= '{sym:      s_tdata[lcs_pkg::SYM_W-1:0],
                   diag:     '0,
                   best_len: best_len,
                   best_col: best_col,
                   hit:      1'b0};
    end
  end

  // Result register: load on delivery, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (deliver_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (deliver_fire) begin
      m_tdata <= {(lcs_pkg::M_TDATA_W - lcs_pkg::FIELDS_W)'(0),
                  lcs_pkg::END_R_W'(best_col),
                  lcs_pkg::END_S_W'(best_row),
                  lcs_pkg::LEN_W'(best_len)};
      m_tuser <= best_len != '0;
    end
  end

endmodule

### hw/rtl/longest_common_substring.sv
// Top level of the longest common substring block: controller plus a row
// of match cells, one per reference symbol. Depends on lcs_pkg, lcs_cell
// and lcs_ctrl.
//
// Usage: requests arrive on the s_ channel. s_tuser carries the opcode
// (append reference symbol, stream symbol, clear), s_tdata the symbol and
// s_tlast marks the final streamed symbol. Append, clear and unused codes
// leave the block ready for the next request. A streamed symbol launches a
// token that walks the cell chain one column per cycle, so the next request
// is taken only once the token has left the last column. A last symbol adds
// a delivery step that loads the result register, and the result then
// waits on the m_ channel: m_tdata holds the length, the streamed end index
// and the reference end index, m_tuser the found flag. While the result
// waits, new requests are still taken; a later last symbol holds in its
// delivery step until the receiver takes the pending result. Reset (rst,
// synchronous) empties the reference and clears all runs and best values.
// The reference survives a result, so a new string may follow at once.
module longest_common_substring (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [lcs_pkg::S_TDATA_W-1:0]   s_tdata,  // [7:0] symbol
  input  logic [lcs_pkg::OP_W-1:0]        s_tuser,  // [1:0] op
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [8:0] match_len, [24:9] end_in_stream, [32:25] end_in_ref, rest zero
  output logic [lcs_pkg::M_TDATA_W-1:0]   m_tdata,
  output logic [0:0]                      m_tuser   // [0] found
);

  lcs_pkg::cell_ctl_t cell_ctl;
  logic               tok_valid [lcs_pkg::MAX_REF_LEN+1];
  lcs_pkg::token_t    tok       [lcs_pkg::MAX_REF_LEN+1];

  lcs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cell_ctl   (cell_ctl),
    .inj_valid  (tok_valid[0]),
    .inj_tok    (tok[0]),
    .done_valid (tok_valid[lcs_pkg::MAX_REF_LEN]),
    .done_tok   (tok[lcs_pkg::MAX_REF_LEN])
  );

  // Chain of cells, column j feeds column j+1
  for (genvar j = 0; j < lcs_pkg::MAX_REF_LEN; j++) begin : g_cell
    lcs_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .idx       (lcs_pkg::IDX_W'(j)),
      .ctl       (cell_ctl),
      .in_valid  (tok_valid[j]),
      .in_tok    (tok[j]),
      .out_valid (tok_valid[j+1]),
      .out_tok   (tok[j+1])
    );
  end

endmodule

### hw/rtl/lcs_checker.sv
// Port-level checks for the longest common substring block, bound to the
// top level. Depends on lcs_pkg.
module lcs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [lcs_pkg::M_TDATA_W-1:0] m_tdata,
  input logic [0:0]                    m_tuser
);

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // Found flag agrees with a nonzero length
  a_found_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[lcs_pkg::LEN_W-1:0] != '0)
    else $error("found set with zero length");

  // No match reports all-zero fields
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("nonzero fields without a match");

  // Reset empties the result register
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind longest_common_substring lcs_checker u_lcs_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

### sim/longest_common_substring_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for longest_common_substring: drives stream and reference
// requests, predicts each match result and compares it. Depends on lcs_pkg.
module longest_common_substring_tb;

  localparam int CLK_HALF = 2;
  localparam int RESET_CYCLES = 7;
  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 300;
  localparam int ROW_MAX = (1 << lcs_pkg::STREAM_INDEX_BITS) - 1;
  localparam logic [lcs_pkg::OP_W-1:0] OP_NONE = 2'd3;

  typedef struct {
    logic [lcs_pkg::LEN_W-1:0]   len;
    logic [lcs_pkg::END_S_W-1:0] end_stream;
    logic [lcs_pkg::END_R_W-1:0] end_ref;
    logic                        found;
  } lcs_result_t;

  // Tracks reference, DP row and best run; holds pending match results
  class lcs_scoreboard;
    logic [lcs_pkg::SYM_W-1:0] ref_sym [lcs_pkg::MAX_REF_LEN];
    int unsigned ref_len;
    int unsigned run_len [lcs_pkg::MAX_REF_LEN];
    int unsigned row, best_len, best_row, best_col;
    lcs_result_t expected_q[$];
    int unsigned mismatches;

    function void clear_stream();
      foreach (run_len[j]) run_len[j] = 0;
      row = 0;
      best_len = 0;
      best_row = 0;
      best_col = 0;
    endfunction

    function void note_request(logic [lcs_pkg::OP_W-1:0] op,
                               logic [lcs_pkg::SYM_W-1:0] sym, logic last);
      int unsigned diag, v;
      lcs_result_t res;
      case (op)
        lcs_pkg::OP_APPEND: begin
          // drop appends once the reference is full
          if (ref_len < lcs_pkg::MAX_REF_LEN) begin
            ref_sym[lcs_pkg::IDX_W'(ref_len)] = sym;
            run_len[lcs_pkg::IDX_W'(ref_len)] = 0;
            ref_len++;
          end
        end
        lcs_pkg::OP_CLEAR: begin
          ref_len = 0;
          clear_stream();
        end
        lcs_pkg::OP_STREAM: begin
          // one DP row: a match extends the diagonal run of the previous row
          diag = 0;
          for (int j = 0; j < ref_len; j++) begin
            v = (ref_sym[lcs_pkg::IDX_W'(j)] == sym) ? diag + 1 : 0;
            if (v > best_len) begin
              best_len = v;
              best_row = row;
              best_col = j;
            end
            diag = run_len[lcs_pkg::IDX_W'(j)];
            run_len[lcs_pkg::IDX_W'(j)] = v;
          end
          if (row < ROW_MAX) row++;
          if (last) begin
            res.found = (best_len > 0);
            res.len = res.found ? best_len[lcs_pkg::LEN_W-1:0] : '0;
            res.end_stream = res.found ? best_row[lcs_pkg::END_S_W-1:0] : '0;
            res.end_ref = res.found ? best_col[lcs_pkg::END_R_W-1:0] : '0;
            expected_q.push_back(res);
            clear_stream();
          end
        end
        default: ;
      endcase
    endfunction

    function void compare(string field, longint unsigned exp, longint unsigned act);
      if (exp != act) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, field, exp, act);
      end
    endfunction

    function void check_result(logic [lcs_pkg::M_TDATA_W-1:0] data, logic [0:0] user);
      lcs_result_t exp;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with none pending: tdata %h tuser %b", $realtime, data, user);
        return;
      end
      exp = expected_q.pop_front();
      compare("match_len", 64'(exp.len), 64'(data[lcs_pkg::LEN_W-1:0]));
      compare("end_in_stream", 64'(exp.end_stream),
              64'(data[lcs_pkg::LEN_W +: lcs_pkg::END_S_W]));
      compare("end_in_ref", 64'(exp.end_ref),
              64'(data[lcs_pkg::LEN_W+lcs_pkg::END_S_W +: lcs_pkg::END_R_W]));
      compare("found", 64'(exp.found), 64'(user[0]));
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [lcs_pkg::S_TDATA_W-1:0] s_tdata = '0;  // [7:0] symbol
  logic [lcs_pkg::OP_W-1:0]      s_tuser = '0;  // [1:0] op
  logic                          s_tlast = 1'b0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  // [8:0] match_len, [24:9] end_in_stream, [32:25] end_in_ref, rest zero
  logic [lcs_pkg::M_TDATA_W-1:0] m_tdata;
  logic [0:0]                    m_tuser;        // [0] found

  lcs_scoreboard sb = new;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned items_sent = 0;
  int unsigned stall_cycles = 0;

  longest_common_substring u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #CLK_HALF clk = ~clk;

  // Take results at random and check each one
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Abort when nothing moves on either side for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Mostly a small alphabet around a base byte, so matches are common
  function automatic logic [lcs_pkg::SYM_W-1:0] pick_symbol(logic [lcs_pkg::SYM_W-1:0] base);
    if ($urandom_range(15) == 0) return lcs_pkg::SYM_W'($urandom);
    return base ^ lcs_pkg::SYM_W'($urandom_range(3));
  endfunction

  // Present one request after a random gap and hold until it is taken
  task automatic send_request(input logic [lcs_pkg::OP_W-1:0] op,
                              input logic [lcs_pkg::SYM_W-1:0] sym,
                              input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= sym;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    sb.note_request(op, sym, last);
    if (op != OP_NONE) items_sent++;
  endtask

  // Hold off the sender until every pending result has been taken
  task automatic wait_results_drained();
    if (sb.expected_q.size() != 0) begin
      s_tvalid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clk);
    end
  endtask

  // One reference/stream session with some noise mixed in
  task automatic run_session();
    int unsigned n_ref, n_str, start;
    logic copy;
    logic [lcs_pkg::SYM_W-1:0] base, sym;
    base = lcs_pkg::SYM_W'($urandom);
    if ($urandom_range(3) == 0)
      send_request(lcs_pkg::OP_CLEAR, lcs_pkg::SYM_W'($urandom), 1'($urandom_range(1)));
    n_ref = ($urandom_range(4) == 0) ? 0 : $urandom_range(1, 12);
    repeat (n_ref) send_request(lcs_pkg::OP_APPEND, pick_symbol(base), 1'($urandom_range(1)));
    n_str = $urandom_range(1, 10);
    start = $urandom_range(255);
    copy = 1'($urandom_range(1));
    for (int i = 0; i < n_str; i++) begin
      if ($urandom_range(19) == 0)
        send_request($urandom_range(1) ? OP_NONE : lcs_pkg::OP_APPEND, pick_symbol(base),
                     1'($urandom_range(1)));
      if (copy && sb.ref_len > 0)
        sym = sb.ref_sym[lcs_pkg::IDX_W'((start + i) % sb.ref_len)];
      else sym = pick_symbol(base);
      // the final symbol sometimes lacks last, so the row runs on
      send_request(lcs_pkg::OP_STREAM, sym, (i == n_str - 1) && ($urandom_range(9) != 0));
    end
  endtask

  initial begin
    logic [lcs_pkg::SYM_W-1:0] base;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // empty reference, unused opcode
    send_request(lcs_pkg::OP_STREAM, 8'h3C, 1'b1);
    send_request(OP_NONE, 8'hFF, 1'b1);
    // reference 00 FF AA 55 FF; last has no effect on appends
    send_request(lcs_pkg::OP_APPEND, 8'h00, 1'b0);
    send_request(lcs_pkg::OP_APPEND, 8'hFF, 1'b0);
    send_request(lcs_pkg::OP_APPEND, 8'hAA, 1'b0);
    send_request(lcs_pkg::OP_APPEND, 8'h55, 1'b1);
    send_request(lcs_pkg::OP_APPEND, 8'hFF, 1'b0);
    // three-symbol run, then a string with nothing in common
    send_request(lcs_pkg::OP_STREAM, 8'hFF, 1'b0);
    send_request(lcs_pkg::OP_STREAM, 8'hAA, 1'b0);
    send_request(lcs_pkg::OP_STREAM, 8'h55, 1'b1);
    send_request(lcs_pkg::OP_STREAM, 8'h77, 1'b1);
    // append during streaming; equal runs keep the earliest column
    send_request(lcs_pkg::OP_STREAM, 8'hFF, 1'b0);
    send_request(lcs_pkg::OP_APPEND, 8'hAA, 1'b0);
    send_request(lcs_pkg::OP_STREAM, 8'hAA, 1'b1);
    send_request(lcs_pkg::OP_STREAM, 8'hFF, 1'b1);
    // clear, then a clear in the middle of a string
    send_request(lcs_pkg::OP_CLEAR, 8'h00, 1'b1);
    send_request(lcs_pkg::OP_STREAM, 8'h01, 1'b1);
    send_request(lcs_pkg::OP_APPEND, 8'h01, 1'b0);
    send_request(lcs_pkg::OP_STREAM, 8'h01, 1'b0);
    send_request(lcs_pkg::OP_CLEAR, 8'hFF, 1'b0);
    send_request(lcs_pkg::OP_APPEND, 8'h02, 1'b0);
    send_request(lcs_pkg::OP_STREAM, 8'h02, 1'b1);
    wait_results_drained();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 68 : 0;
      recv_idle_pct = (phase == 0) ? 68 : (phase == 1) ? 20 : 0;
      if (phase == 0) begin
        // overfill the reference, then match its tail
        base = lcs_pkg::SYM_W'($urandom);
        send_request(lcs_pkg::OP_CLEAR, 8'h00, 1'b0);
        repeat (lcs_pkg::MAX_REF_LEN + 4)
          send_request(lcs_pkg::OP_APPEND, pick_symbol(base), 1'b1);
        for (int i = lcs_pkg::MAX_REF_LEN - 6; i < lcs_pkg::MAX_REF_LEN; i++)
          send_request(lcs_pkg::OP_STREAM, sb.ref_sym[lcs_pkg::IDX_W'(i)],
                       i == lcs_pkg::MAX_REF_LEN - 1);
      end
      while (items_sent < (phase + 1) * 1400 / 3) run_session();
      // close any open string so every phase ends with a result
      send_request(lcs_pkg::OP_STREAM, lcs_pkg::SYM_W'($urandom), 1'b1);
      wait_results_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      if (sb.expected_q.size() != 0)
        $display("%0d results never arrived", sb.expected_q.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
